[src/amf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package amf_pkg;

  localparam int SPAN       = 7;
  localparam int HALF       = 3;
  localparam int LINES      = 6;
  localparam int NWIN       = 49;
  localparam int CENTRE     = 24;
  localparam int NSIZE      = 3;
  localparam int MIN_SIZE   = 8;
  localparam int MAX_HEIGHT = 1024;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = 5;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // window codes
  localparam logic [1:0] WIN_3X3 = 2'd0;
  localparam logic [1:0] WIN_5X5 = 2'd1;
  localparam logic [1:0] WIN_7X7 = 2'd2;

  typedef struct packed {
    logic       last;
    logic [1:0] used;
    logic [7:0] pixel;
  } result_t;

  // elements of the window of half size m+1, row-major over the 7x7 grid
  function automatic logic [NWIN-1:0] win_mask(input int m);
    logic [NWIN-1:0] v;
    v = '0;
    for (int k = 0; k < SPAN; k++) begin
      for (int j = 0; j < SPAN; j++) begin
        if (k >= HALF - m - 1 && k <= HALF + m + 1 && j >= HALF - m - 1 && j <= HALF + m + 1)
          v[k*SPAN+j] = 1'b1;
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[src/amf_rank.sv]
`timescale 1ns / 1ps
`default_nettype none
module amf_rank (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [amf_pkg::NWIN-1:0][7:0]  in_dat,
  input  wire logic                           in_last,
  output logic                                out_valid,
  output amf_pkg::result_t                    out_res
);

  // radix selection, one bit per stage from the msb: min, median and max
  // for each of the three window sizes
  logic [amf_pkg::NWIN-1:0][7:0] dat [0:8];
  logic [amf_pkg::NWIN-1:0]      mn  [0:8][0:2];
  logic [amf_pkg::NWIN-1:0]      mx  [0:8][0:2];
  logic [amf_pkg::NWIN-1:0]      md  [0:8][0:2];
  logic [5:0]                    kk  [0:8][0:2];
  logic [7:0]                    vmn [0:8][0:2];
  logic [7:0]                    vmx [0:8][0:2];
  logic [7:0]                    vmd [0:8][0:2];
  logic                          vld [0:8];
  logic                          lst [0:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    dat[0] <= in_dat;
    lst[0] <= in_last;
    for (int m = 0; m < amf_pkg::NSIZE; m++) begin
      mn[0][m]  <= amf_pkg::win_mask(m);
      mx[0][m]  <= amf_pkg::win_mask(m);
      md[0][m]  <= amf_pkg::win_mask(m);
      kk[0][m]  <= 6'(((2*m+3)*(2*m+3))/2);
      vmn[0][m] <= '0;
      vmx[0][m] <= '0;
      vmd[0][m] <= '0;
    end
  end

  for (genvar s = 0; s < 8; s++) begin : g_stage
    localparam int B = 7 - s;
    logic [amf_pkg::NWIN-1:0] ones;
    logic [amf_pkg::NWIN-1:0] nmn [0:2];
    logic [amf_pkg::NWIN-1:0] nmx [0:2];
    logic [amf_pkg::NWIN-1:0] nmd [0:2];
    logic [5:0]               nkk [0:2];
    logic                     bmn [0:2];
    logic                     bmx [0:2];
    logic                     bmd [0:2];

    always_comb begin
      logic [amf_pkg::NWIN-1:0] z;
      logic [amf_pkg::NWIN-1:0] o;
      logic [5:0]               cnt;
      for (int i = 0; i < amf_pkg::NWIN; i++) ones[i] = dat[s][i][B];
      for (int m = 0; m < amf_pkg::NSIZE; m++) begin
        z = mn[s][m] & ~ones;
        if (z != '0) begin
          bmn[m] = 1'b0;
          nmn[m] = z;
        end else begin
          bmn[m] = 1'b1;
          nmn[m] = mn[s][m];
        end
        o = mx[s][m] & ones;
        if (o != '0) begin
          bmx[m] = 1'b1;
          nmx[m] = o;
        end else begin
          bmx[m] = 1'b0;
          nmx[m] = mx[s][m];
        end
        z = md[s][m] & ~ones;
        cnt = '0;
        for (int i = 0; i < amf_pkg::NWIN; i++) cnt = cnt + 6'(z[i]);
        if (kk[s][m] < cnt) begin
          bmd[m] = 1'b0;
          nmd[m] = z;
          nkk[m] = kk[s][m];
        end else begin
          bmd[m] = 1'b1;
          nmd[m] = md[s][m] & ones;
          nkk[m] = kk[s][m] - cnt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      dat[s+1] <= dat[s];
      lst[s+1] <= lst[s];
      for (int m = 0; m < amf_pkg::NSIZE; m++) begin
        mn[s+1][m]  <= nmn[m];
        mx[s+1][m]  <= nmx[m];
        md[s+1][m]  <= nmd[m];
        kk[s+1][m]  <= nkk[m];
        vmn[s+1][m] <= vmn[s][m] | (8'(bmn[m]) << B);
        vmx[s+1][m] <= vmx[s][m] | (8'(bmx[m]) << B);
        vmd[s+1][m] <= vmd[s][m] | (8'(bmd[m]) << B);
      end
    end
  end

  // smallest window whose median is strictly inside its range decides; if none is, the 7x7 median is output
  amf_pkg::result_t res;
  always_comb begin
    logic [7:0] ctr;
    ctr = dat[8][amf_pkg::CENTRE];
    res.last  = lst[8];
    res.used  = amf_pkg::WIN_7X7;
    res.pixel = vmd[8][2];
    for (int m = amf_pkg::NSIZE - 1; m >= 0; m--) begin
      if (vmn[8][m] < vmd[8][m] && vmd[8][m] < vmx[8][m]) begin
        res.used  = 2'(m);
        res.pixel = (vmn[8][m] < ctr && ctr < vmx[8][m]) ? ctr : vmd[8][m];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[8];
    end
    out_res <= res;
  end

endmodule
`default_nettype wire

[src/adaptive_median_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Adaptive median filter over 8-bit grey pixels in raster order, 3x3 growing to 5x5 and 7x7,
// zero outside the image. One pixel beat per clock is taken while the 32-entry output queue
// has room. The six previous rows live in one line memory, one word of six pixels per column,
// read and written back once per beat. After the frame, 3*image_width+3 flush beats drain the
// last results; the last result of a frame carries tlast and restarts the counters. Register
// writes restart the frame.
module adaptive_median_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // pixel_in
  input  wire logic [0:0]  s_tuser,   // flush
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // pixel_out
  output logic [1:0]       m_tuser,   // window_used
  output logic             m_tlast,   // frame_end
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int WV = (WW > 11) ? WW : 11;
  localparam int MW = amf_pkg::LINES * 8;

  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [CW-1:0] cc;
  logic [10:0]   rc;

  // clamped sizes
  logic [WV-1:0] wv;
  logic [WW-1:0] w;
  logic [10:0]   h;
  always_comb begin
    wv = WV'(width_reg);
    if (wv < WV'(amf_pkg::MIN_SIZE)) wv = WV'(amf_pkg::MIN_SIZE);
    if (wv > WV'(MAX_WIDTH)) wv = WV'(MAX_WIDTH);
    w = WW'(wv);
    h = height_reg;
    if (h < 11'(amf_pkg::MIN_SIZE)) h = 11'(amf_pkg::MIN_SIZE);
    if (h > 11'(amf_pkg::MAX_HEIGHT)) h = 11'(amf_pkg::MAX_HEIGHT);
  end

  logic acc;
  assign acc = s_tvalid && s_tready;

  logic [7:0]    pix;
  logic [WW-1:0] ccw;
  logic [WW-1:0] cc1;
  logic          emit;
  logic [10:0]   r0;
  logic [WW-1:0] c0;
  logic          last0;
  logic [CW-1:0] cc_next;
  logic [10:0]   rc_next;
  always_comb begin
    pix = s_tuser[0] ? 8'd0 : s_tdata;
    ccw = {1'b0, cc};
    if (ccw >= w) ccw = '0;
    emit = 1'b0;
    r0 = '0;
    c0 = '0;
    if (ccw >= WW'(amf_pkg::HALF) && rc >= 11'(amf_pkg::HALF)
        && rc - 11'(amf_pkg::HALF) < h) begin
      emit = 1'b1;
      r0 = rc - 11'(amf_pkg::HALF);
      c0 = ccw - WW'(amf_pkg::HALF);
    end else if (ccw < WW'(amf_pkg::HALF) && rc >= 11'(amf_pkg::HALF + 1)
                 && rc - 11'(amf_pkg::HALF + 1) < h) begin
      emit = 1'b1;
      r0 = rc - 11'(amf_pkg::HALF + 1);
      c0 = ccw + w - WW'(amf_pkg::HALF);
    end
    last0 = emit && r0 == h - 11'd1 && c0 == w - WW'(1);
    cc1 = ccw + WW'(1);
    cc_next = cc1[CW-1:0];
    rc_next = rc;
    if (cc1 >= w) begin
      cc_next = '0;
      rc_next = rc + 11'd1;
    end
    if (last0) begin
      cc_next = '0;
      rc_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd640;
      height_reg <= 11'd480;
      cc <= '0;
      rc <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        amf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
        amf_pkg::REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
      cc <= '0;
      rc <= '0;
    end else if (acc) begin
      cc <= cc_next;
      rc <= rc_next;
    end
  end

  // line memory: read on the accept edge, write back the shifted column in the next cycle
  logic [MW-1:0] line_mem [0:MAX_WIDTH-1];
  logic [MW-1:0] mem_q;
  logic          s1_valid;
  logic          s1_emit;
  logic [CW-1:0] s1_cc;
  logic [7:0]    s1_pix;
  logic [10:0]   s1_r;
  logic [WW-1:0] s1_c;
  logic          s1_last;

  always_ff @(posedge clk) begin
    if (acc) mem_q <= line_mem[ccw[CW-1:0]];
    if (s1_valid) line_mem[s1_cc] <= {s1_pix, mem_q[MW-1:8]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
    s1_emit <= emit;
    s1_cc   <= ccw[CW-1:0];
    s1_pix  <= pix;
    s1_r    <= r0;
    s1_c    <= c0;
    s1_last <= last0;
  end

  logic [7:0] win [0:amf_pkg::SPAN-1][0:amf_pkg::SPAN-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < amf_pkg::SPAN; k++)
        for (int j = 0; j < amf_pkg::SPAN; j++) win[k][j] <= '0;
    end else if (s1_valid) begin
      for (int k = 0; k < amf_pkg::SPAN; k++) begin
        for (int j = 0; j < amf_pkg::SPAN - 1; j++) win[k][j] <= win[k][j+1];
        win[k][amf_pkg::SPAN-1] <= (k < amf_pkg::LINES) ? mem_q[k*8 +: 8] : s1_pix;
      end
    end
  end

  logic          s2_valid;
  logic [10:0]   s2_r;
  logic [WW-1:0] s2_c;
  logic          s2_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
    s2_r    <= s1_r;
    s2_c    <= s1_c;
    s2_last <= s1_last;
  end

  // zero the parts of the window outside the image
  logic [amf_pkg::SPAN-1:0]      row_ok;
  logic [amf_pkg::SPAN-1:0]      col_ok;
  logic [amf_pkg::NWIN-1:0][7:0] snap;
  always_comb begin
    logic [11:0] rk;
    logic [WW:0] cj;
    for (int k = 0; k < amf_pkg::SPAN; k++) begin
      rk = {1'b0, s2_r} + 12'(k);
      row_ok[k] = rk >= 12'(amf_pkg::HALF) && rk - 12'(amf_pkg::HALF) < {1'b0, h};
      cj = {1'b0, s2_c} + (WW+1)'(k);
      col_ok[k] = cj >= (WW+1)'(amf_pkg::HALF) && cj - (WW+1)'(amf_pkg::HALF) < {1'b0, w};
    end
    for (int k = 0; k < amf_pkg::SPAN; k++)
      for (int j = 0; j < amf_pkg::SPAN; j++)
        snap[k*amf_pkg::SPAN+j] = (row_ok[k] && col_ok[j]) ? win[k][j] : 8'd0;
  end

  logic             rk_valid;
  amf_pkg::result_t rk_res;
  amf_rank u_rank (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_dat    (snap),
    .in_last   (s2_last),
    .out_valid (rk_valid),
    .out_res   (rk_res)
  );

  // output queue; pending counts results in flight plus queued ones
  amf_pkg::result_t              fifo [0:amf_pkg::FIFO_DEPTH-1];
  logic [amf_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [amf_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [amf_pkg::FIFO_AW:0]     fcount;
  logic [amf_pkg::FIFO_AW:0]     pending;
  logic                          pop;

  assign m_tvalid = fcount != '0;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = fifo[rd_ptr].pixel;
  assign m_tuser  = fifo[rd_ptr].used;
  assign m_tlast  = fifo[rd_ptr].last;
  assign s_tready = pending < (amf_pkg::FIFO_AW+1)'(amf_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rk_valid) fifo[wr_ptr] <= rk_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fcount  <= '0;
      pending <= '0;
    end else begin
      if (rk_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fcount  <= fcount + (amf_pkg::FIFO_AW+1)'(rk_valid) - (amf_pkg::FIFO_AW+1)'(pop);
      pending <= pending + (amf_pkg::FIFO_AW+1)'(acc && emit) - (amf_pkg::FIFO_AW+1)'(pop);
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (amf_pkg::FIFO_AW+1)'(amf_pkg::FIFO_DEPTH))
    else $error("pending count beyond queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rk_valid |-> fcount < (amf_pkg::FIFO_AW+1)'(amf_pkg::FIFO_DEPTH))
    else $error("result written into full queue");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    fcount <= pending)
    else $error("queue holds more than pending count");

  a_emit_path: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid))
    else $error("window snapshot without a column shift");

endmodule
`default_nettype wire
